// ----- hw/rtl/rar_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the fraction arithmetic unit
// Operand and result widths, operation and status codes, the payload structs
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int unsigned DATA_WIDTH = 16;
  // magnitudes of products and sums of products
  localparam int unsigned PROD_W     = 2 * DATA_WIDTH;
  localparam int unsigned CNT_W      = $clog2(PROD_W + 1);
  localparam int unsigned NUM_W      = 33;
  localparam int unsigned DEN_W      = 31;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DEN = 2'd1,
    STAT_DIV_ZERO = 2'd2
  } status_e;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    MS_AN_BD = 2'd0,
    MS_AD_BN = 2'd1,
    MS_AD_BD = 2'd2,
    MS_AN_BN = 2'd3
  } msel_e;

  typedef enum logic [3:0] {
    CMD_NONE      = 4'd0,
    CMD_LOAD      = 4'd1,
    CMD_MUL       = 4'd2,
    CMD_SET_NUM   = 4'd3,
    CMD_SET_DEN   = 4'd4,
    CMD_ACC_NUM   = 4'd5,
    CMD_GCD_INIT  = 4'd6,
    CMD_GCD_STEP  = 4'd7,
    CMD_DIV_NUM   = 4'd8,
    CMD_DIV_DEN   = 4'd9,
    CMD_DIV_STEP  = 4'd10,
    CMD_STORE_OUT = 4'd11
  } cmd_e;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [DATA_WIDTH-1:0] a_num;
    logic signed [DATA_WIDTH-1:0] a_den;
    logic signed [DATA_WIDTH-1:0] b_num;
    logic signed [DATA_WIDTH-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] result_num;
    logic [DEN_W-1:0]        result_den;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    cmd_e  cmd;
    msel_e msel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       err;
    logic       num_zero;
    logic       gcd_done;
    logic       div_done;
  } dp_stat_t;

endpackage

// ----- hw/rtl/rar_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_dpath: fraction arithmetic datapath
// Holds the operands, forms cross products on one shared multiplier, reduces
// by a binary GCD and divides numerator and denominator by it bit-serially.
// ----------------------------------------------------------------------------
module rar_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rar_pkg::in_t      in_data_i,
  input  rar_pkg::dp_cmd_t  cmd_i,
  output rar_pkg::dp_stat_t stat_o,
  output rar_pkg::out_t     out_data_o
);
  import rar_pkg::*;

  in_t                   in_q;
  logic [DATA_WIDTH-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic                  an_neg, ad_neg, bn_neg, bd_neg;

  logic [DATA_WIDTH-1:0] op_x, op_y;
  logic                  op_x_neg, op_y_neg;
  logic [PROD_W-1:0]     mul_res;

  logic [PROD_W-1:0]     prod_q, prod_d;
  logic                  prod_neg_q, prod_neg_d;
  logic [PROD_W-1:0]     num_mag_q, num_mag_d, den_mag_q, den_mag_d;
  logic                  num_neg_q, num_neg_d, den_neg_q, den_neg_d;

  logic                  add_neg;
  logic [PROD_W-1:0]     sum_mag;
  logic                  sum_neg;

  logic [PROD_W-1:0]     u_q, u_d, v_q, v_d;
  logic [CNT_W-1:0]      k_q, k_d;
  logic [PROD_W-1:0]     g_q, g_d;
  logic [PROD_W-1:0]     rem_q, rem_d, dq_q, dq_d, qn_q, qn_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [PROD_W:0]       rem_w;
  logic                  rem_ge;

  status_e               stat_val;
  logic [NUM_W-1:0]      q_ext;
  out_t                  out_q, out_d;

  function automatic logic [DATA_WIDTH-1:0] sm_mag(input logic [DATA_WIDTH-1:0] x);
    return x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

  assign an_mag = sm_mag(in_q.a_num);
  assign ad_mag = sm_mag(in_q.a_den);
  assign bn_mag = sm_mag(in_q.b_num);
  assign bd_mag = sm_mag(in_q.b_den);
  assign an_neg = in_q.a_num[DATA_WIDTH-1];
  assign ad_neg = in_q.a_den[DATA_WIDTH-1];
  assign bn_neg = in_q.b_num[DATA_WIDTH-1];
  assign bd_neg = in_q.b_den[DATA_WIDTH-1];

  always_comb begin
    case (cmd_i.msel)
      MS_AN_BD: begin op_x = an_mag; op_y = bd_mag; op_x_neg = an_neg; op_y_neg = bd_neg; end
      MS_AD_BN: begin op_x = ad_mag; op_y = bn_mag; op_x_neg = ad_neg; op_y_neg = bn_neg; end
      MS_AD_BD: begin op_x = ad_mag; op_y = bd_mag; op_x_neg = ad_neg; op_y_neg = bd_neg; end
      MS_AN_BN: begin op_x = an_mag; op_y = bn_mag; op_x_neg = an_neg; op_y_neg = bn_neg; end
      default:  begin op_x = an_mag; op_y = bd_mag; op_x_neg = an_neg; op_y_neg = bd_neg; end
    endcase
  end

  assign mul_res = op_x * op_y;

  // signed-magnitude accumulate; the second term is negated for subtract
  always_comb begin
    add_neg = (prod_neg_q ^ (in_q.kind == KIND_SUB)) && (prod_q != '0);
    if (num_neg_q == add_neg) begin
      sum_mag = num_mag_q + prod_q;
      sum_neg = num_neg_q;
    end else if (num_mag_q >= prod_q) begin
      sum_mag = num_mag_q - prod_q;
      sum_neg = num_neg_q;
    end else begin
      sum_mag = prod_q - num_mag_q;
      sum_neg = add_neg;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  always_comb begin
    if (in_q.a_den == '0 || in_q.b_den == '0) begin
      stat_val = STAT_ZERO_DEN;
    end else if (in_q.kind == KIND_DIV && in_q.b_num == '0) begin
      stat_val = STAT_DIV_ZERO;
    end else begin
      stat_val = STAT_OK;
    end
  end

  assign rem_w  = {rem_q, dq_q[PROD_W-1]};
  assign rem_ge = rem_w >= {1'b0, g_q};
  assign q_ext  = NUM_W'(qn_q);

  always_comb begin
    prod_d     = prod_q;
    prod_neg_d = prod_neg_q;
    num_mag_d  = num_mag_q;
    num_neg_d  = num_neg_q;
    den_mag_d  = den_mag_q;
    den_neg_d  = den_neg_q;
    u_d        = u_q;
    v_d        = v_q;
    k_d        = k_q;
    g_d        = g_q;
    rem_d      = rem_q;
    dq_d       = dq_q;
    qn_d       = qn_q;
    cnt_d      = cnt_q;
    out_d      = out_q;
    case (cmd_i.cmd)
      CMD_MUL: begin
        prod_d     = mul_res;
        prod_neg_d = (op_x_neg ^ op_y_neg) && (mul_res != '0);
      end
      CMD_SET_NUM: begin
        num_mag_d = prod_q;
        num_neg_d = prod_neg_q;
      end
      CMD_SET_DEN: begin
        den_mag_d = prod_q;
        den_neg_d = prod_neg_q;
      end
      CMD_ACC_NUM: begin
        num_mag_d = sum_mag;
        num_neg_d = sum_neg;
      end
      CMD_GCD_INIT: begin
        u_d = num_mag_q;
        v_d = den_mag_q;
        k_d = '0;
      end
      CMD_GCD_STEP: begin
        // binary GCD: strip common twos, drop lone twos, halve odd differences
        if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q >= v_q) begin
          u_d = (u_q - v_q) >> 1;
        end else begin
          v_d = (v_q - u_q) >> 1;
        end
      end
      CMD_DIV_NUM: begin
        g_d   = (u_q | v_q) << k_q;
        rem_d = '0;
        dq_d  = num_mag_q;
        cnt_d = '0;
      end
      CMD_DIV_DEN: begin
        qn_d  = dq_q;
        rem_d = '0;
        dq_d  = den_mag_q;
        cnt_d = '0;
      end
      CMD_DIV_STEP: begin
        rem_d = rem_ge ? PROD_W'(rem_w - {1'b0, g_q}) : rem_w[PROD_W-1:0];
        dq_d  = {dq_q[PROD_W-2:0], rem_ge};
        cnt_d = cnt_q + 1'b1;
      end
      CMD_STORE_OUT: begin
        out_d.status = stat_val;
        if (stat_val != STAT_OK || num_mag_q == '0) begin
          out_d.result_num = '0;
          out_d.result_den = DEN_W'(1);
        end else begin
          out_d.result_num = (num_neg_q ^ den_neg_q) ? (~q_ext + 1'b1) : q_ext;
          out_d.result_den = DEN_W'(dq_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == CMD_LOAD) begin
      in_q <= in_data_i;
    end
    prod_q     <= prod_d;
    prod_neg_q <= prod_neg_d;
    num_mag_q  <= num_mag_d;
    num_neg_q  <= num_neg_d;
    den_mag_q  <= den_mag_d;
    den_neg_q  <= den_neg_d;
    u_q        <= u_d;
    v_q        <= v_d;
    k_q        <= k_d;
    g_q        <= g_d;
    rem_q      <= rem_d;
    dq_q       <= dq_d;
    qn_q       <= qn_d;
    cnt_q      <= cnt_d;
    out_q      <= out_d;
  end

  assign stat_o.kind     = in_q.kind;
  assign stat_o.err      = (stat_val != STAT_OK);
  assign stat_o.num_zero = (num_mag_q == '0);
  assign stat_o.gcd_done = (u_q == '0) || (v_q == '0);
  assign stat_o.div_done = (cnt_q == CNT_W'(PROD_W));
  assign out_data_o      = out_q;

`ifndef NO_ASSERTIONS
  a_gcd_step_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmd == CMD_GCD_STEP |-> (u_q != '0 && v_q != '0))
    else $error("gcd step issued with a zero operand");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmd == CMD_DIV_STEP |-> g_q != '0)
    else $error("divide step with zero divisor");
`endif

endmodule

// ----- hw/rtl/rar_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_ctrl: fraction arithmetic sequencer
// Steps the datapath through operand check, cross products, GCD and the two
// divisions, and owns both handshakes and the output valid flag.
// ----------------------------------------------------------------------------
module rar_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rar_pkg::dp_cmd_t  cmd_o,
  input  rar_pkg::dp_stat_t stat_i
);
  import rar_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_TAKE1 = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_TAKE2 = 4'd5;
  localparam logic [3:0] S_MUL3  = 4'd6;
  localparam logic [3:0] S_TAKE3 = 4'd7;
  localparam logic [3:0] S_ZCHK  = 4'd8;
  localparam logic [3:0] S_GCD   = 4'd9;
  localparam logic [3:0] S_DIVN  = 4'd10;
  localparam logic [3:0] S_DIVD  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       is_addsub;

  assign is_addsub = (stat_i.kind == KIND_ADD) || (stat_i.kind == KIND_SUB);

  always_comb begin
    state_d     = state_q;
    cmd_o.cmd   = CMD_NONE;
    cmd_o.msel  = MS_AN_BD;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cmd = CMD_LOAD;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = stat_i.err ? S_DONE : S_MUL1;
      end
      S_MUL1: begin
        cmd_o.cmd  = CMD_MUL;
        cmd_o.msel = (stat_i.kind == KIND_MUL) ? MS_AN_BN : MS_AN_BD;
        state_d    = S_TAKE1;
      end
      S_TAKE1: begin
        cmd_o.cmd = CMD_SET_NUM;
        state_d   = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.cmd  = CMD_MUL;
        cmd_o.msel = (stat_i.kind == KIND_MUL) ? MS_AD_BD : MS_AD_BN;
        state_d    = S_TAKE2;
      end
      S_TAKE2: begin
        if (is_addsub) begin
          cmd_o.cmd = CMD_ACC_NUM;
          state_d   = S_MUL3;
        end else begin
          cmd_o.cmd = CMD_SET_DEN;
          state_d   = S_ZCHK;
        end
      end
      S_MUL3: begin
        cmd_o.cmd  = CMD_MUL;
        cmd_o.msel = MS_AD_BD;
        state_d    = S_TAKE3;
      end
      S_TAKE3: begin
        cmd_o.cmd = CMD_SET_DEN;
        state_d   = S_ZCHK;
      end
      S_ZCHK: begin
        cmd_o.cmd = CMD_GCD_INIT;
        state_d   = stat_i.num_zero ? S_DONE : S_GCD;
      end
      S_GCD: begin
        if (stat_i.gcd_done) begin
          cmd_o.cmd = CMD_DIV_NUM;
          state_d   = S_DIVN;
        end else begin
          cmd_o.cmd = CMD_GCD_STEP;
        end
      end
      S_DIVN: begin
        if (stat_i.div_done) begin
          cmd_o.cmd = CMD_DIV_DEN;
          state_d   = S_DIVD;
        end else begin
          cmd_o.cmd = CMD_DIV_STEP;
        end
      end
      S_DIVD: begin
        if (stat_i.div_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.cmd = CMD_DIV_STEP;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.cmd   = CMD_STORE_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result valid raised outside the done state");

  a_gcd_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GCD && !stat_i.gcd_done) |=> state_q == S_GCD)
    else $error("left gcd loop before it converged");
`endif

endmodule

// ----- hw/rtl/rational_arith_reduce_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_reduce_unit: signed fraction add/sub/mul/div in lowest terms
// Forms the cross products of two fractions, reduces by their GCD and
// returns a positive denominator, with a status for zero denominators and
// division by a zero fraction.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  in       | in_valid_i / in_stall_o | in_data_i  (kind, a/b num/den)
//  out      | out_valid_o/out_stall_i | out_data_o (result_num, result_den,
//           |                         |             status)
//
// One transaction at a time: from accept to stored result come the fixed
// sequencer states, the binary GCD steps plus one exit step, and two
// bit-serial divisions of numerator and denominator by the GCD.
// Error inputs go to the store right after the operand check; zero
// numerators skip the GCD and both divisions.
// A finished result waits in the output register while the next input is
// taken; a stalled output blocks only the final store.
// Reset clears the sequencer and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module rational_arith_reduce_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rar_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rar_pkg::out_t out_data_o
);
  import rar_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  rar_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .out_data_o (out_data_o)
  );

endmodule
